/* rtl/core/ggnh_pkg.sv */
// ggnh_pkg: shared types and constants of the greedy grid next-hop selector
// no dependencies
`timescale 1ns / 1ps
package ggnh_pkg;

  localparam int GridRows   = 4;
  localparam int GridCols   = 6;
  localparam int MaxNodes   = 4096;
  localparam int NumCells   = GridRows * GridCols;
  localparam int TableDepth = NumCells * NumCells * 4;
  localparam int TableAw    = $clog2(TableDepth);

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CAND  = 2'd2;

  localparam logic CFG_CELL_SIZE = 1'b0;
  localparam logic CFG_HOP_RANGE = 1'b1;

  localparam logic signed [15:0] NoRoute = -16'sd256;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         table_src_cell;
    logic [4:0]         table_dst_cell;
    logic [1:0]         table_dir;
    logic signed [15:0] table_score;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [15:0]        dest_x;
    logic [15:0]        dest_y;
    logic [11:0]        neighbor_id;
    logic               neighbor_is_dest;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [11:0] next_hop_id;
    logic [1:0]  chosen_slot;
  } out_word_t;

endpackage

/* rtl/core/grid_greedy_next_hop_select_core.sv */
// grid_greedy_next_hop_select_core: greedy grid next-hop selector top level
// depends on ggnh_pkg
// order: a write is taken while idle; a query runs four divides (pos x, y, dest x, y), the
//   score reads and the rank; a candidate runs two divides, 4 multiplies, 1 update, and the last
//   candidate then strobes done_o; writes go back to back while idle; nothing new while busy;
//   the receiver cannot stall
// reset: asynchronous, active low; registers to 1000 / 500, no query open; score memory not cleared
`timescale 1ns / 1ps
module grid_greedy_next_hop_select_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ggnh_pkg::in_word_t  word_i,
  output logic                done_o,
  output ggnh_pkg::out_word_t word_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import ggnh_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;  // divide pos (x then y) by cell size
  localparam logic [3:0] S_DIVD   = 4'd2;  // query: divide dest x, y
  localparam logic [3:0] S_RD     = 4'd3;  // issue score reads
  localparam logic [3:0] S_RDW    = 4'd4;
  localparam logic [3:0] S_RANK   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;  // candidate squared distances
  localparam logic [3:0] S_UPD    = 4'd7;

  logic [3:0] state_q, state_d;

  logic [15:0] cell_size_q, hop_range_q;
  in_word_t    word_q;

  // score memory, registered read
  logic signed [15:0] mem [TableDepth];
  logic               mem_we;
  logic [TableAw-1:0] mem_wa, mem_ra;
  logic signed [15:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= word_i.table_score;
    mem_rd_q <= mem[mem_ra];
  end

  // restoring divider, one quotient bit per cycle
  logic [15:0] div_rem_q, div_quo_q, div_num_q;
  logic [4:0]  div_cnt_q;
  logic [15:0] div_den;
  logic [16:0] div_trial;
  assign div_den   = (cell_size_q == 16'd0) ? 16'd1 : cell_size_q;
  assign div_trial = {div_rem_q, div_num_q[15]} - {1'b0, div_den};

  // quotients: 0 src/cand x, 1 src/cand y, 2 dest x, 3 dest y
  logic [15:0] quo_q [4];
  logic [1:0]  div_sel_q;

  // query state
  logic        active_q, own_only_q, dest_hit_q;
  logic [11:0] dest_hop_q;
  logic [15:0] trow_q [3];
  logic [15:0] tcol_q [3];
  logic [2:0]  tval_q, found_q;
  logic [33:0] best_q [3];
  logic [11:0] hop_q  [3];
  logic [15:0] qpos_q [4];
  logic signed [15:0] sc_q [4];
  logic [2:0]  rd_cnt_q;

  // candidate distance pipe
  logic [1:0]  mul_cnt_q;
  logic [31:0] sq_q [4];
  logic [15:0] mul_a;
  logic [31:0] mul_p;

  always_comb begin
    logic [15:0] a, b;
    case (mul_cnt_q)
      2'd0:    begin a = word_q.pos_x; b = qpos_q[2]; end
      2'd1:    begin a = word_q.pos_y; b = qpos_q[3]; end
      2'd2:    begin a = word_q.pos_x; b = qpos_q[0]; end
      default: begin a = word_q.pos_y; b = qpos_q[1]; end
    endcase
    mul_a = (a > b) ? a - b : b - a;
    mul_p = mul_a * mul_a;
  end

  logic [33:0] dd, ds;
  logic [31:0] hr_sq_q;
  assign dd = {2'b00, sq_q[0]} + {2'b00, sq_q[1]};
  assign ds = {2'b00, sq_q[2]} + {2'b00, sq_q[3]};

  // score ranking
  logic [2:0] first_dir, second_dir;  // bit 2 set: none
  always_comb begin
    logic signed [15:0] mx;
    first_dir = 3'b100;
    mx = NoRoute;
    for (int i = 0; i < 4; i++)
      if (sc_q[i] > mx) begin first_dir = 3'(i); mx = sc_q[i]; end
    second_dir = 3'b100;
    mx = NoRoute;
    for (int i = 0; i < 4; i++)
      if (3'(i) != first_dir && sc_q[i] > mx) begin second_dir = 3'(i); mx = sc_q[i]; end
  end

  logic all_none, in_grid;
  assign all_none = !in_grid || (sc_q[0] == NoRoute && sc_q[1] == NoRoute &&
                                 sc_q[2] == NoRoute && sc_q[3] == NoRoute);
  assign in_grid = quo_q[1] < 16'(GridRows) && quo_q[0] < 16'(GridCols) &&
                   quo_q[3] < 16'(GridRows) && quo_q[2] < 16'(GridCols);

  // base address of the (source cell, destination cell) entry
  logic [TableAw-1:0] base_addr;
  assign base_addr = TableAw'(((quo_q[1][3:0] * GridCols + quo_q[0][3:0]) * NumCells
                     + quo_q[3][3:0] * GridCols + quo_q[2][3:0]) * 4);

  assign mem_we = start && !busy && word_i.func == FUNC_WRITE &&
                  word_i.table_src_cell < 5'(NumCells) &&
                  word_i.table_dst_cell < 5'(NumCells);
  assign mem_wa = TableAw'((word_i.table_src_cell * NumCells + word_i.table_dst_cell) * 4
                  + word_i.table_dir);
  assign mem_ra = base_addr + TableAw'(rd_cnt_q[1:0]);

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:
        if (start && (word_i.func == FUNC_QUERY ||
                      (word_i.func == FUNC_CAND && active_q))) state_d = S_DIV;
      S_DIV:
        if (div_cnt_q == 5'd16 && div_sel_q == 2'd1)
          state_d = (word_q.func == FUNC_QUERY) ? S_DIVD : S_MUL;
      S_DIVD:  if (div_cnt_q == 5'd16 && div_sel_q == 2'd3) state_d = S_RD;
      S_RD:    state_d = S_RDW;
      S_RDW:   if (rd_cnt_q == 3'd4) state_d = S_RANK;
      S_RANK:  state_d = S_IDLE;
      S_MUL:   if (mul_cnt_q == 2'd3) state_d = S_UPD;
      S_UPD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // neighbor cell for a direction; returns {valid, row, col}
  function automatic logic [8:0] nb(input logic [2:0] dir, input logic [3:0] r,
                                    input logic [3:0] c);
    logic [8:0] res;
    res = {1'b1, r, c};
    case (dir)
      3'd0:    res = (r == 4'd0) ? {1'b0, 8'hFF} : {1'b1, r - 4'd1, c};
      3'd1:    res = {1'b1, r + 4'd1, c};
      3'd2:    res = (c == 4'd0) ? {1'b0, 8'hFF} : {1'b1, r, c - 4'd1};
      3'd3:    res = {1'b1, r, c + 4'd1};
      default: res = {1'b0, 8'hFF};
    endcase
    return res;
  endfunction

  logic [8:0] nb0, nb1;
  assign nb0 = nb(first_dir, quo_q[1][3:0], quo_q[0][3:0]);
  assign nb1 = nb(second_dir, quo_q[1][3:0], quo_q[0][3:0]);

  // candidate cell, full quotient width so an own cell outside the grid still matches
  logic [2:0] slot_hit;
  always_comb begin
    for (int i = 0; i < 3; i++)
      slot_hit[i] = tval_q[i] && (own_only_q ? i == 0 : 1'b1) &&
                    quo_q[1] == trow_q[i] && quo_q[0] == tcol_q[i];
  end

  logic cand_ok;
  assign cand_ok = !dest_hit_q && (32'(word_q.neighbor_id) < 32'(MaxNodes));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cell_size_q <= 16'd1000;
      hop_range_q <= 16'd500;
      active_q    <= 1'b0;
      own_only_q  <= 1'b0;
      dest_hit_q  <= 1'b0;
      dest_hop_q  <= '0;
      tval_q      <= '0;
      found_q     <= '0;
      done_o      <= 1'b0;
      word_o      <= '0;
      div_cnt_q   <= '0;
      div_sel_q   <= '0;
      rd_cnt_q    <= '0;
      mul_cnt_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        trow_q[i] <= 16'hF;
        tcol_q[i] <= 16'hF;
        best_q[i] <= '1;
        hop_q[i]  <= '0;
      end
      for (int i = 0; i < 4; i++) qpos_q[i] <= '0;
    end else begin
      state_q <= state_d;
      // strobe for exactly the cycle after the closing update
      done_o  <= (state_q == S_UPD) && word_q.last;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CELL_SIZE) cell_size_q <= cfg_data_i;
        else                            hop_range_q <= cfg_data_i;
      end
      unique case (state_q) inside
        S_IDLE: begin
          div_cnt_q <= '0;
          div_sel_q <= '0;
          div_rem_q <= '0;
          div_num_q <= word_i.pos_x;
          rd_cnt_q  <= '0;
          mul_cnt_q <= '0;
          hr_sq_q   <= hop_range_q * hop_range_q;
          if (start) word_q <= word_i;
        end
        S_DIV, S_DIVD: begin
          if (div_cnt_q == 5'd16) begin
            quo_q[div_sel_q] <= div_quo_q;
            div_sel_q <= div_sel_q + 2'd1;
            div_cnt_q <= '0;
            div_rem_q <= '0;
            case (div_sel_q)
              2'd0:    div_num_q <= word_q.pos_y;
              2'd1:    div_num_q <= word_q.dest_x;
              default: div_num_q <= word_q.dest_y;
            endcase
          end else begin
            div_cnt_q <= div_cnt_q + 5'd1;
            div_num_q <= {div_num_q[14:0], 1'b0};
            if (!div_trial[16]) begin
              div_rem_q <= div_trial[15:0];
              div_quo_q <= {div_quo_q[14:0], 1'b1};
            end else begin
              div_rem_q <= {div_rem_q[14:0], div_num_q[15]};
              div_quo_q <= {div_quo_q[14:0], 1'b0};
            end
          end
        end
        S_RD:  rd_cnt_q <= 3'd1;
        S_RDW: begin
          sc_q[rd_cnt_q[1:0] - 2'd1] <= mem_rd_q;
          rd_cnt_q <= rd_cnt_q + 3'd1;
        end
        S_RANK: begin
          active_q   <= 1'b1;
          dest_hit_q <= 1'b0;
          dest_hop_q <= '0;
          found_q    <= '0;
          qpos_q[0] <= word_q.pos_x;  qpos_q[1] <= word_q.pos_y;
          qpos_q[2] <= word_q.dest_x; qpos_q[3] <= word_q.dest_y;
          for (int i = 0; i < 3; i++) begin
            best_q[i] <= '1;
            hop_q[i]  <= '0;
          end
          if (all_none) begin
            own_only_q <= 1'b1;
            tval_q     <= 3'b001;
            trow_q[0] <= quo_q[1]; tcol_q[0] <= quo_q[0];
            trow_q[1] <= 16'hF; tcol_q[1] <= 16'hF;
            trow_q[2] <= 16'hF; tcol_q[2] <= 16'hF;
          end else begin
            own_only_q <= 1'b0;
            tval_q     <= {1'b1, nb1[8], nb0[8]};
            trow_q[0] <= {12'd0, nb0[7:4]}; tcol_q[0] <= {12'd0, nb0[3:0]};
            trow_q[1] <= {12'd0, nb1[7:4]}; tcol_q[1] <= {12'd0, nb1[3:0]};
            trow_q[2] <= quo_q[1]; tcol_q[2] <= quo_q[0];
          end
        end
        S_MUL: begin
          sq_q[mul_cnt_q] <= mul_p;
          mul_cnt_q <= mul_cnt_q + 2'd1;
        end
        S_UPD: begin
          if (cand_ok) begin
            if (word_q.neighbor_is_dest) begin
              dest_hit_q <= 1'b1;
              dest_hop_q <= word_q.neighbor_id;
            end else begin
              for (int i = 0; i < 3; i++)
                if (slot_hit[i] && dd < best_q[i] && ds <= {2'b00, hr_sq_q}) begin
                  best_q[i]  <= dd;
                  hop_q[i]   <= word_q.neighbor_id;
                  found_q[i] <= 1'b1;
                end
            end
          end
          if (word_q.last) begin
            active_q <= 1'b0;
            if (cand_ok && word_q.neighbor_is_dest)
              word_o <= '{found: 1'b1, next_hop_id: word_q.neighbor_id, chosen_slot: 2'd3};
            else if (dest_hit_q)
              word_o <= '{found: 1'b1, next_hop_id: dest_hop_q, chosen_slot: 2'd3};
            else begin
              logic [2:0] f;
              f = found_q;
              for (int i = 0; i < 3; i++)
                if (cand_ok && slot_hit[i] && dd < best_q[i] && ds <= {2'b00, hr_sq_q})
                  f[i] = 1'b1;
              if (f[0])
                word_o <= '{found: 1'b1, next_hop_id: (cand_ok && slot_hit[0] &&
                  dd < best_q[0] && ds <= {2'b00, hr_sq_q}) ? word_q.neighbor_id : hop_q[0],
                  chosen_slot: 2'd0};
              else if (f[1])
                word_o <= '{found: 1'b1, next_hop_id: (cand_ok && slot_hit[1] &&
                  dd < best_q[1] && ds <= {2'b00, hr_sq_q}) ? word_q.neighbor_id : hop_q[1],
                  chosen_slot: 2'd1};
              else if (f[2])
                word_o <= '{found: 1'b1, next_hop_id: (cand_ok && slot_hit[2] &&
                  dd < best_q[2] && ds <= {2'b00, hr_sq_q}) ? word_q.neighbor_id : hop_q[2],
                  chosen_slot: 2'd2};
              else
                word_o <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
